// File: hw/rtl/pfg_pkg.sv
package pfg_pkg;

  // configuration register indexes
  localparam logic CFG_DIFF_STEP  = 1'b0;
  localparam logic CFG_CELL_WIDTH = 1'b1;

  localparam logic [28:0] DIFF_STEP_RST  = 29'd1073742;
  localparam logic [30:0] CELL_WIDTH_RST = 31'd1048576;

  // potential clamp, 2^61
  localparam logic        [63:0] FLIM_U = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] FLIM_P = 64'sh2000_0000_0000_0000;
  localparam logic signed [63:0] FLIM_N = -64'sh2000_0000_0000_0000;

  localparam logic [5:0] SER_STEPS   = 6'd32;
  localparam logic [6:0] DIV_FULL    = 7'd64;
  localparam logic [6:0] DIV_HALF    = 7'd32;

  typedef struct packed {
    logic        start;
    logic [6:0]  steps;
    logic [63:0] rem_init;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/pfg_if.sv
interface pfg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               last_particle;
  modport source (output valid, pos_x, pos_y, last_particle, input ready);
  modport sink   (input valid, pos_x, pos_y, last_particle, output ready);
endinterface

interface pfg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic        [31:0] speed;
  logic        [31:0] peak_speed;
  logic        [31:0] step_time;
  logic               set_done;
  modport source (output valid, vel_x, vel_y, speed, peak_speed, step_time, set_done,
                  input ready);
  modport sink   (input valid, vel_x, vel_y, speed, peak_speed, step_time, set_done,
                  output ready);
endinterface

interface pfg_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/potential_flow_gradient_cfl.sv
// Each result is worked out by the bit-serial squarer, the shared restoring divider and
//   the square root; samples at zero x or zero radius skip their divide.
// Throughput: one particle at a time; the next input transfer is taken once the result
//   has moved into the output register, even while that result waits to be taken.
// Reset (rst_n low, synchronous): idle, output empty, running peak zero, registers default.
module potential_flow_gradient_cfl #(
  parameter int COORD_FRAC_BITS = 28
) (
  input  logic     clk,
  input  logic     rst_n,
  pfg_in_if.sink   in_ch,
  pfg_out_if.source out_ch,
  pfg_cfg_if.sink  cfg_ch
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_PREP  = 16'h0002,
    S_SQX   = 16'h0004,
    S_SQY   = 16'h0008,
    S_CHK   = 16'h0010,
    S_TDIV  = 16'h0020,
    S_TERM  = 16'h0040,
    S_VCHK  = 16'h0080,
    S_VDIV  = 16'h0100,
    S_VEL   = 16'h0200,
    S_MPREP = 16'h0400,
    S_MULVX = 16'h0800,
    S_MULVY = 16'h1000,
    S_ROOT  = 16'h2000,
    S_TSDIV = 16'h4000,
    S_FIN   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [28:0] diff_step_r;
  logic [30:0] cell_width_r;

  // item registers
  logic signed [31:0] x_r, y_r;
  logic               last_r;
  logic [28:0]        h_r;
  logic [1:0]         pt_r, pt_nxt;      // sample point: +x, -x, +y, -y
  logic               v_r, v_nxt;        // velocity component in progress
  logic [5:0]         cnt_r, cnt_nxt;    // serial step counter

  // serial squarer: a times the low half of prod, one bit a cycle
  logic [31:0] mul_a_r, mul_a_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [32:0] mul_sum;

  logic [63:0] r2_r, r2_nxt;
  logic [63:0] t_r, t_nxt;
  logic signed [63:0] f_r [4];
  logic signed [63:0] f_nxt;
  logic               f_we;

  logic [32:0] vq_r, vq_nxt;
  logic        vneg_r, vneg_nxt;
  logic signed [31:0] vx_r, vy_r, vel_nxt;
  logic               vx_we, vy_we;

  // square root, two radicand bits a cycle
  logic [63:0] s_r, s_nxt;
  logic [32:0] srem_r, srem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [34:0] sq_trial, sq_test, sq_diff;

  logic [31:0] speed_r, speed_nxt;
  logic [31:0] peak_r, peak_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [31:0] run_peak_r, run_peak_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_vx_r, out_vy_r;
  logic [31:0]        out_speed_r, out_peak_r, out_ts_r;
  logic               out_done_r;
  logic               fin_load;

  pfg_pkg::div_req_t  div_req;
  pfg_pkg::div_stat_t div_st;
  logic [63:0]        div_quo;

  pfg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .stat (div_st),
    .quo  (div_quo)
  );

  // sample point and its magnitudes
  logic signed [32:0] x33, y33, hx, px, py;
  logic [32:0]        px_neg, py_neg;
  logic [31:0]        ax, ay;
  logic [63:0]        ax64;

  assign x33 = {x_r[31], x_r};
  assign y33 = {y_r[31], y_r};
  assign hx  = {4'b0000, h_r};

  always_comb begin
    px = x33;
    py = y33;
    case (pt_r)
      2'd0:    px = x33 + hx;
      2'd1:    px = x33 - hx;
      2'd2:    py = y33 + hx;
      2'd3:    py = y33 - hx;
      default: px = x33;
    endcase
  end

  assign px_neg = -px;
  assign py_neg = -py;
  assign ax     = px[32] ? px_neg[31:0] : px[31:0];
  assign ay     = py[32] ? py_neg[31:0] : py[31:0];
  assign ax64   = {32'd0, ax};

  // potential term and clamp
  logic [63:0]        t_clamp;
  logic signed [63:0] term, f_raw;

  assign t_clamp = (t_r > pfg_pkg::FLIM_U) ? pfg_pkg::FLIM_U : t_r;
  assign term    = px[32] ? -$signed(t_clamp) : $signed(t_clamp);
  assign f_raw   = {{31{px[32]}}, px} + term;

  always_comb begin
    if (f_raw > pfg_pkg::FLIM_P)      f_nxt = pfg_pkg::FLIM_P;
    else if (f_raw < pfg_pkg::FLIM_N) f_nxt = pfg_pkg::FLIM_N;
    else                              f_nxt = f_raw;
  end

  // central difference numerator and denominator
  logic signed [63:0] fd;
  logic [63:0]        fd_neg, num, den64;
  logic               vovf;

  assign fd     = v_r ? (f_r[2] - f_r[3]) : (f_r[0] - f_r[1]);
  assign fd_neg = -fd;
  assign num    = fd[63] ? fd_neg : fd;
  assign den64  = {34'd0, h_r, 1'b0};
  // quotient at or above 2^32 saturates either way
  assign vovf   = (num >> 12) >= den64;

  logic [32:0] vq_neg;
  assign vq_neg = -vq_r;

  always_comb begin
    if (vneg_r) vel_nxt = (vq_r > 33'h0_8000_0000) ? 32'sh8000_0000 : vq_neg[31:0];
    else        vel_nxt = (vq_r > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : vq_r[31:0];
  end

  logic [31:0] vx_neg, vy_neg, vx_abs, vy_abs;
  assign vx_neg = -vx_r;
  assign vy_neg = -vy_r;
  assign vx_abs = vx_r[31] ? vx_neg : vx_r;
  assign vy_abs = vy_r[31] ? vy_neg : vy_r;

  assign mul_sum  = {1'b0, prod_r[63:32]} + (prod_r[0] ? {1'b0, mul_a_r} : 33'd0);

  assign sq_test  = {srem_r, s_r[63:62]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_diff  = sq_test - sq_trial;

  logic [31:0] peak_cand;
  assign peak_cand = (root_r > run_peak_r) ? root_r : run_peak_r;

  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    pt_nxt       = pt_r;
    v_nxt        = v_r;
    cnt_nxt      = cnt_r;
    mul_a_nxt    = mul_a_r;
    prod_nxt     = prod_r;
    r2_nxt       = r2_r;
    t_nxt        = t_r;
    f_we         = 1'b0;
    vq_nxt       = vq_r;
    vneg_nxt     = vneg_r;
    vx_we        = 1'b0;
    vy_we        = 1'b0;
    s_nxt        = s_r;
    srem_nxt     = srem_r;
    root_nxt     = root_r;
    speed_nxt    = speed_r;
    peak_nxt     = peak_r;
    ts_nxt       = ts_r;
    run_peak_nxt = run_peak_r;
    div_req      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          pt_nxt    = 2'd0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        mul_a_nxt = ax;
        prod_nxt  = {32'd0, ax};
        cnt_nxt   = pfg_pkg::SER_STEPS;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        if (cnt_r != '0) begin
          prod_nxt = {mul_sum, prod_r[31:1]};
          cnt_nxt  = cnt_r - 6'd1;
        end else begin
          r2_nxt    = prod_r >> COORD_FRAC_BITS;
          mul_a_nxt = ay;
          prod_nxt  = {32'd0, ay};
          cnt_nxt   = pfg_pkg::SER_STEPS;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        if (cnt_r != '0) begin
          prod_nxt = {mul_sum, prod_r[31:1]};
          cnt_nxt  = cnt_r - 6'd1;
        end else begin
          r2_nxt    = r2_r + (prod_r >> COORD_FRAC_BITS);
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (ax == '0) begin
          t_nxt     = '0;
          state_nxt = S_TERM;
        end else if (r2_r == '0) begin
          // scaled squared radius truncates to zero
          t_nxt     = pfg_pkg::FLIM_U;
          state_nxt = S_TERM;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = pfg_pkg::DIV_FULL;
          div_req.rem_init = '0;
          div_req.dividend = ax64 << COORD_FRAC_BITS;
          div_req.divisor  = r2_r;
          state_nxt        = S_TDIV;
        end
      end
      S_TDIV: begin
        if (div_st.done) begin
          t_nxt     = div_quo;
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        f_we = 1'b1;
        if (pt_r == 2'd3) begin
          v_nxt     = 1'b0;
          state_nxt = S_VCHK;
        end else begin
          pt_nxt    = pt_r + 2'd1;
          state_nxt = S_PREP;
        end
      end
      S_VCHK: begin
        vneg_nxt = fd[63];
        if (vovf) begin
          vq_nxt    = 33'h1_0000_0000;
          state_nxt = S_VEL;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = pfg_pkg::DIV_HALF;
          div_req.rem_init = num >> 12;
          div_req.dividend = {num[11:0], 52'd0};
          div_req.divisor  = den64;
          state_nxt        = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_st.done) begin
          vq_nxt    = {1'b0, div_quo[31:0]};
          state_nxt = S_VEL;
        end
      end
      S_VEL: begin
        if (!v_r) begin
          vx_we     = 1'b1;
          v_nxt     = 1'b1;
          state_nxt = S_VCHK;
        end else begin
          vy_we     = 1'b1;
          state_nxt = S_MPREP;
        end
      end
      S_MPREP: begin
        mul_a_nxt = vx_abs;
        prod_nxt  = {32'd0, vx_abs};
        cnt_nxt   = pfg_pkg::SER_STEPS;
        state_nxt = S_MULVX;
      end
      S_MULVX: begin
        if (cnt_r != '0) begin
          prod_nxt = {mul_sum, prod_r[31:1]};
          cnt_nxt  = cnt_r - 6'd1;
        end else begin
          s_nxt     = prod_r;
          mul_a_nxt = vy_abs;
          prod_nxt  = {32'd0, vy_abs};
          cnt_nxt   = pfg_pkg::SER_STEPS;
          state_nxt = S_MULVY;
        end
      end
      S_MULVY: begin
        if (cnt_r != '0) begin
          prod_nxt = {mul_sum, prod_r[31:1]};
          cnt_nxt  = cnt_r - 6'd1;
        end else begin
          s_nxt     = s_r + prod_r;
          srem_nxt  = '0;
          root_nxt  = '0;
          cnt_nxt   = pfg_pkg::SER_STEPS;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (cnt_r != '0) begin
          s_nxt   = {s_r[61:0], 2'b00};
          cnt_nxt = cnt_r - 6'd1;
          if (!sq_diff[34]) begin
            srem_nxt = sq_diff[32:0];
            root_nxt = {root_r[30:0], 1'b1};
          end else begin
            srem_nxt = sq_test[32:0];
            root_nxt = {root_r[30:0], 1'b0};
          end
        end else begin
          speed_nxt = root_r;
          peak_nxt  = peak_cand;
          if (peak_cand == '0) begin
            ts_nxt    = '1;
            state_nxt = S_FIN;
          end else begin
            div_req.start    = 1'b1;
            div_req.steps    = pfg_pkg::DIV_FULL;
            div_req.rem_init = '0;
            div_req.dividend = {13'd0, cell_width_r, 20'd0};
            div_req.divisor  = {32'd0, peak_cand};
            state_nxt        = S_TSDIV;
          end
        end
      end
      S_TSDIV: begin
        if (div_st.done) begin
          ts_nxt    = (div_quo[63:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          run_peak_nxt = last_r ? 32'd0 : peak_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      run_peak_r   <= '0;
      diff_step_r  <= pfg_pkg::DIFF_STEP_RST;
      cell_width_r <= pfg_pkg::CELL_WIDTH_RST;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      run_peak_r   <= run_peak_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          pfg_pkg::CFG_DIFF_STEP:  diff_step_r  <= cfg_ch.data[28:0];
          pfg_pkg::CFG_CELL_WIDTH: cell_width_r <= cfg_ch.data[30:0];
          default:                 diff_step_r  <= diff_step_r;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      x_r    <= in_ch.pos_x;
      y_r    <= in_ch.pos_y;
      last_r <= in_ch.last_particle;
      h_r    <= (diff_step_r == '0) ? 29'd1 : diff_step_r;
    end
    pt_r    <= pt_nxt;
    v_r     <= v_nxt;
    mul_a_r <= mul_a_nxt;
    prod_r  <= prod_nxt;
    r2_r    <= r2_nxt;
    t_r     <= t_nxt;
    if (f_we) f_r[pt_r] <= f_nxt;
    vq_r    <= vq_nxt;
    vneg_r  <= vneg_nxt;
    if (vx_we) vx_r <= vel_nxt;
    if (vy_we) vy_r <= vel_nxt;
    s_r     <= s_nxt;
    srem_r  <= srem_nxt;
    root_r  <= root_nxt;
    speed_r <= speed_nxt;
    peak_r  <= peak_nxt;
    ts_r    <= ts_nxt;
    if (fin_load) begin
      out_vx_r    <= vx_r;
      out_vy_r    <= vy_r;
      out_speed_r <= speed_r;
      out_peak_r  <= peak_r;
      out_ts_r    <= ts_r;
      out_done_r  <= last_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.vel_x      = out_vx_r;
  assign out_ch.vel_y      = out_vy_r;
  assign out_ch.speed      = out_speed_r;
  assign out_ch.peak_speed = out_peak_r;
  assign out_ch.step_time  = out_ts_r;
  assign out_ch.set_done   = out_done_r;

  // divider is never restarted mid-run
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_st.busy)
    else $error("divider started while busy");

  // running peak covers the speed reported with it
  a_peak_ge_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.peak_speed >= out_ch.speed))
    else $error("peak below speed");

  // peak clears after the last particle of a set
  a_peak_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_load && last_r) |=> (run_peak_r == '0))
    else $error("running peak not cleared");

  // zero peak gives the largest step
  a_zero_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.peak_speed == '0) |-> (out_ch.step_time == 32'hFFFF_FFFF))
    else $error("step time not saturated");

endmodule

// File: hw/rtl/pfg_div.sv
// Restoring divider, one quotient bit per cycle.
module pfg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pfg_pkg::div_req_t req,
  output pfg_pkg::div_stat_t stat,
  output logic [63:0]       quo
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [64:0] trial;
  logic [64:0] diff;

  assign trial = {rem_r, dvd_r[63]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      cnt_nxt = req.steps;
      rem_nxt = req.rem_init;
      dvd_nxt = req.dividend;
      dsr_nxt = req.divisor;
      quo_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
      dvd_nxt  = {dvd_r[62:0], 1'b0};
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule
